>>> design/mocu_pkg.sv
// Shared constants, types and helper functions for the mipmap occupancy counter.
`default_nettype none
package mocu_pkg;

  localparam int MAX_LEVEL = 8;
  localparam int LVL_W     = 4;
  localparam int COORD_W   = 8;
  localparam int COUNT_W   = 17;
  localparam int ACTION_W  = 2;
  localparam int STATE_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DEPTH     = ((1 << (2 * (MAX_LEVEL + 1))) - 1) / 3;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [ACTION_W-1:0] ACT_TURN_ON = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  localparam logic [STATE_W-1:0] CELL_EMPTY   = 2'd0;
  localparam logic [STATE_W-1:0] CELL_PARTIAL = 2'd1;
  localparam logic [STATE_W-1:0] CELL_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MAX = 1'b1;

  typedef struct packed {
    logic [LVL_W-1:0] min_level;
    logic [LVL_W-1:0] active_max_level;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0]   lvl;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } addr_req_t;

  // First entry of a level: sum of 4^k for k below the level.
  function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] l);
    logic [ADDR_W-1:0] b;
    b = '0;
    for (int k = 0; k < MAX_LEVEL; k++) begin
      if (LVL_W'(k) < l) begin
        b[2*k] = 1'b1;
      end
    end
    return b;
  endfunction

  function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] v);
    return (v > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : v;
  endfunction

endpackage
`default_nettype wire

>>> design/mocu_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module mocu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> design/mocu_addr.sv
// Cell address unit: maps level and coordinates to a flat pyramid address.
`default_nettype none
module mocu_addr (
  input  wire mocu_pkg::addr_req_t          req_i,
  output logic [mocu_pkg::ADDR_W-1:0]       addr_o
);

  assign addr_o = mocu_pkg::level_base(req_i.lvl)
                + (mocu_pkg::ADDR_W'(req_i.y) << req_i.lvl)
                + mocu_pkg::ADDR_W'(req_i.x);

endmodule
`default_nettype wire

>>> design/mocu_seq.sv
// Sequencer: walks the pyramid levels, sweeps clears and holds the result register.
`default_nettype none
module mocu_seq (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mocu_pkg::cfg_t                    cfg_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [mocu_pkg::ACTION_W-1:0]     action_i,
  input  wire logic [mocu_pkg::LVL_W-1:0]        level_i,
  input  wire logic [mocu_pkg::COORD_W-1:0]      x_coord_i,
  input  wire logic [mocu_pkg::COORD_W-1:0]      y_coord_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mocu_pkg::STATE_W-1:0]           cell_state_o,
  output logic [mocu_pkg::COUNT_W-1:0]           cell_count_o,
  output logic                                   error_o,
  output logic                                   ram_we_o,
  output logic [mocu_pkg::ADDR_W-1:0]            ram_waddr_o,
  output logic [mocu_pkg::COUNT_W-1:0]           ram_wdata_o,
  output logic [mocu_pkg::ADDR_W-1:0]            ram_raddr_o,
  input  wire logic [mocu_pkg::COUNT_W-1:0]      ram_rdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FCHK = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_QCHK = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [mocu_pkg::ADDR_W-1:0] LAST_ADDR = mocu_pkg::ADDR_W'(mocu_pkg::DEPTH - 1);

  logic [2:0]                     state_q, state_d;
  logic                           report_q, report_d;
  logic [mocu_pkg::ADDR_W-1:0]    clr_q, clr_d;
  logic                           out_valid_q, out_valid_d;
  logic [mocu_pkg::LVL_W-1:0]     lvl_q, lvl_d;
  logic [mocu_pkg::COORD_W-1:0]   xs_q, xs_d, ys_q, ys_d;
  logic [mocu_pkg::ADDR_W-1:0]    wa_q, wa_d;
  logic [mocu_pkg::COUNT_W-1:0]   full_q, full_d;
  logic [mocu_pkg::STATE_W-1:0]   res_st_q, res_st_d, out_st_q, out_st_d;
  logic [mocu_pkg::COUNT_W-1:0]   res_cnt_q, res_cnt_d, out_cnt_q, out_cnt_d;
  logic                           res_err_q, res_err_d, out_err_q, out_err_d;
  mocu_pkg::addr_req_t            req;
  logic [mocu_pkg::ADDR_W-1:0]    addr;
  logic                           accept;
  logic                           out_free;
  logic [mocu_pkg::LVL_W-1:0]     full_sh;

  mocu_addr u_addr (
    .req_i  (req),
    .addr_o (addr)
  );

  assign in_ready_o   = (state_q == S_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign cell_state_o = out_st_q;
  assign cell_count_o = out_cnt_q;
  assign error_o      = out_err_q;
  assign ram_raddr_o  = addr;
  assign full_sh      = cfg_i.active_max_level - level_i;

  always_comb begin
    req.lvl = lvl_q - mocu_pkg::LVL_W'(1);
    req.x   = xs_q >> 1;
    req.y   = ys_q >> 1;
    if (state_q == S_IDLE) begin
      req.lvl = (action_i == mocu_pkg::ACT_QUERY) ? level_i : cfg_i.active_max_level;
      req.x   = x_coord_i;
      req.y   = y_coord_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    report_d    = report_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    lvl_d       = lvl_q;
    xs_d        = xs_q;
    ys_d        = ys_q;
    wa_d        = wa_q;
    full_d      = full_q;
    res_st_d    = res_st_q;
    res_cnt_d   = res_cnt_q;
    res_err_d   = res_err_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    out_err_d   = out_err_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_st_d  = mocu_pkg::CELL_EMPTY;
          res_cnt_d = '0;
          res_err_d = 1'b0;
          case (action_i)
            mocu_pkg::ACT_TURN_ON: begin
              if (cfg_i.min_level > cfg_i.active_max_level ||
                  (x_coord_i >> cfg_i.active_max_level) != '0 ||
                  (y_coord_i >> cfg_i.active_max_level) != '0) begin
                res_err_d = 1'b1;
                state_d   = S_DONE;
              end else begin
                lvl_d   = cfg_i.active_max_level;
                xs_d    = x_coord_i;
                ys_d    = y_coord_i;
                wa_d    = addr;
                state_d = S_FCHK;
              end
            end
            mocu_pkg::ACT_QUERY: begin
              if (level_i < cfg_i.min_level || level_i > cfg_i.active_max_level ||
                  (x_coord_i >> level_i) != '0 || (y_coord_i >> level_i) != '0) begin
                res_err_d = 1'b1;
                state_d   = S_DONE;
              end else begin
                full_d  = mocu_pkg::COUNT_W'(1) << {full_sh, 1'b0};
                state_d = S_QCHK;
              end
            end
            mocu_pkg::ACT_CLEAR: begin
              clr_d    = '0;
              report_d = 1'b1;
              state_d  = S_CLR;
            end
            default: begin
              res_err_d = 1'b1;
              state_d   = S_DONE;
            end
          endcase
        end
      end
      S_FCHK: begin
        if (ram_rdata_i != '0) begin
          res_err_d = 1'b1;
          res_cnt_d = ram_rdata_i;
          state_d   = S_DONE;
        end else begin
          ram_we_o    = 1'b1;
          ram_wdata_o = mocu_pkg::COUNT_W'(1);
          res_cnt_d   = mocu_pkg::COUNT_W'(1);
          if (lvl_q == cfg_i.min_level) begin
            state_d = S_DONE;
          end else begin
            lvl_d   = lvl_q - mocu_pkg::LVL_W'(1);
            xs_d    = xs_q >> 1;
            ys_d    = ys_q >> 1;
            wa_d    = addr;
            state_d = S_UP;
          end
        end
      end
      S_UP: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = (ram_rdata_i == mocu_pkg::COUNT_MAX) ? ram_rdata_i
                                                          : ram_rdata_i + mocu_pkg::COUNT_W'(1);
        if (lvl_q == cfg_i.min_level) begin
          state_d = S_DONE;
        end else begin
          lvl_d = lvl_q - mocu_pkg::LVL_W'(1);
          xs_d  = xs_q >> 1;
          ys_d  = ys_q >> 1;
          wa_d  = addr;
        end
      end
      S_QCHK: begin
        res_cnt_d = ram_rdata_i;
        if (ram_rdata_i == '0) begin
          res_st_d = mocu_pkg::CELL_EMPTY;
        end else if (ram_rdata_i >= full_q) begin
          res_st_d  = mocu_pkg::CELL_FULL;
          res_err_d = (ram_rdata_i > full_q);
        end else begin
          res_st_d = mocu_pkg::CELL_PARTIAL;
        end
        state_d = S_DONE;
      end
      S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        if (clr_q == LAST_ADDR) begin
          state_d = report_q ? S_DONE : S_IDLE;
        end else begin
          clr_d = clr_q + mocu_pkg::ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_cnt_d   = res_cnt_q;
          out_err_d   = res_err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      report_q    <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      report_q    <= report_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    xs_q      <= xs_d;
    ys_q      <= ys_d;
    wa_q      <= wa_d;
    full_q    <= full_d;
    res_st_q  <= res_st_d;
    res_cnt_q <= res_cnt_d;
    res_err_q <= res_err_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
    out_err_q <= out_err_d;
  end

endmodule
`default_nettype wire

>>> design/mipmap_occupancy_counter_unit.sv
// Top level of the mipmap occupancy counter: config registers, sequencer and count RAM.
//
// Keeps a pyramid of 17-bit cell counts in one RAM of 87381 entries (levels 0..8)
// with one write and one read port. A turn-on does one read-modify-write per pyramid
// level, each level's read overlapping the previous level's write, plus the fine-pixel
// check and the result load. A clear writes zero to every RAM entry, one a cycle; the
// same sweep runs after reset, during which in_ready_o stays low (configuration writes
// are taken). One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
`default_nettype none
module mipmap_occupancy_counter_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mocu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mocu_pkg::LVL_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [mocu_pkg::ACTION_W-1:0]     action_i,
  input  wire logic [mocu_pkg::LVL_W-1:0]        level_i,
  input  wire logic [mocu_pkg::COORD_W-1:0]      x_coord_i,
  input  wire logic [mocu_pkg::COORD_W-1:0]      y_coord_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mocu_pkg::STATE_W-1:0]           cell_state_o,
  output logic [mocu_pkg::COUNT_W-1:0]           cell_count_o,
  output logic                                   error_o
);

  mocu_pkg::cfg_t               cfg_q, cfg_d;
  logic                         ram_we;
  logic [mocu_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [mocu_pkg::COUNT_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mocu_pkg::REG_MIN_LEVEL:  cfg_d.min_level        = mocu_pkg::sat_level(cfg_data_i);
        mocu_pkg::REG_ACTIVE_MAX: cfg_d.active_max_level = mocu_pkg::sat_level(cfg_data_i);
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_level        <= '0;
      cfg_q.active_max_level <= mocu_pkg::LVL_W'(mocu_pkg::MAX_LEVEL);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mocu_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .level_i      (level_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_state_o (cell_state_o),
    .cell_count_o (cell_count_o),
    .error_o      (error_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  mocu_ram #(
    .WIDTH (mocu_pkg::COUNT_W),
    .DEPTH (mocu_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire

>>> verif/mipmap_occupancy_counter_unit_test.sv
// Testbench for the mipmap occupancy counter: directed and random traffic checked against a count pyramid.
module mipmap_occupancy_counter_unit_test;
  import mocu_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 95;
  // level register settings for the first ten random phases; values above MAX_LEVEL saturate
  localparam int PHASE_MIN [10] = '{0, 0, 1, 4, 0, 8, 6, 2, 12, 3};
  localparam int PHASE_TOP [10] = '{8, 2, 3, 8, 0, 8, 3, 5, 15, 9};

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [COUNT_W-1:0] count;
    logic               err;
  } cell_result_t;

  class pyramid_tracker;
    logic [COUNT_W-1:0] counts [DEPTH];
    int unsigned        min_lvl;
    int unsigned        top_lvl;
    cell_result_t       pending_results [$];
    int                 mismatches;

    function new();
      wipe();
      min_lvl    = 0;
      top_lvl    = MAX_LEVEL;
      mismatches = 0;
    endfunction

    function void wipe();
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function int unsigned slot(int unsigned l, int unsigned x, int unsigned y);
      return ((1 << (2 * l)) - 1) / 3 + (y << l) + x;
    endfunction

    function void set_level(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] val);
      int unsigned lv;
      lv = (val > MAX_LEVEL) ? MAX_LEVEL : val;
      if (idx == REG_MIN_LEVEL) begin
        min_lvl = lv;
      end else begin
        top_lvl = lv;
      end
    endfunction

    function void note_transfer(logic [ACTION_W-1:0] act, logic [LVL_W-1:0] lvl,
                                logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      cell_result_t r;
      int unsigned  fine, idx, l, full, cnt;
      r = '0;
      case (act)
        ACT_TURN_ON: begin
          if (min_lvl > top_lvl || x >= (1 << top_lvl) || y >= (1 << top_lvl)) begin
            r.err = 1'b1;
          end else begin
            fine = slot(top_lvl, x, y);
            if (counts[fine] != 0) begin
              r.err   = 1'b1;
              r.count = counts[fine];
            end else begin
              l = top_lvl + 1;
              do begin
                l--;
                idx = slot(l, x >> (top_lvl - l), y >> (top_lvl - l));
                if (counts[idx] != COUNT_MAX) counts[idx] = counts[idx] + 1'b1;
              end while (l != min_lvl);
              r.count = counts[fine];
            end
          end
        end
        ACT_QUERY: begin
          if (lvl < min_lvl || lvl > top_lvl || x >= (1 << lvl) || y >= (1 << lvl)) begin
            r.err = 1'b1;
          end else begin
            full    = 1 << (2 * (top_lvl - lvl));
            cnt     = counts[slot(lvl, x, y)];
            r.count = COUNT_W'(cnt);
            if (cnt == 0) begin
              r.state = CELL_EMPTY;
            end else if (cnt >= full) begin
              r.state = CELL_FULL;
              r.err   = (cnt > full);
            end else begin
              r.state = CELL_PARTIAL;
            end
          end
        end
        ACT_CLEAR: wipe();
        default: r.err = 1'b1;
      endcase
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void flag(string field, int unsigned exp_v, int unsigned got_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, expected nothing, %s %0d count %0d err %0d",
                 $time, "actual state", got.state, got.count, got.err);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.state !== exp_r.state) flag("cell_state", exp_r.state, got.state);
      if (got.count !== exp_r.count) flag("cell_count", exp_r.count, got.count);
      if (got.err !== exp_r.err) flag("error", exp_r.err, got.err);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [LVL_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ACTION_W-1:0]  action_i;
  logic [LVL_W-1:0]     level_i;
  logic [COORD_W-1:0]   x_coord_i;
  logic [COORD_W-1:0]   y_coord_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATE_W-1:0]   cell_state_o;
  logic [COUNT_W-1:0]   cell_count_o;
  logic                 error_o;

  pyramid_tracker book = new();
  int             tx_mode;
  int             rx_mode;
  int unsigned    cycles = 0;
  int unsigned    last_x, last_y;
  bit             have_pixel = 1'b0;

  mipmap_occupancy_counter_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .level_i      (level_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_state_o (cell_state_o),
    .cell_count_o (cell_count_o),
    .error_o      (error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      book.check_result({cell_state_o, cell_count_o, error_o});
    end
  end

  // mostly short gaps, a few long; mode 0 never idles
  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < (mode == 1 ? 70 : 35)) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int stall;
    out_ready_i = 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        stall = pick_gap(rx_mode);
      end
    end
  end

  task automatic write_level_reg(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.set_level(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_item(logic [ACTION_W-1:0] act, logic [LVL_W-1:0] lvl,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int gap;
    gap = pick_gap(tx_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    level_i    = lvl;
    x_coord_i  = x;
    y_coord_i  = y;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_transfer(act, lvl, x, y);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (book.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // mostly in-range turn-ons and queries near recent pixels, the rest noise
  task automatic send_random_item();
    int unsigned         pick, top, lo, lvl, x, y, sh;
    logic [ACTION_W-1:0] act;
    top  = book.top_lvl;
    lo   = book.min_lvl;
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      if (have_pixel && $urandom_range(0, 6) == 0) begin
        x = last_x;
        y = last_y;
      end else begin
        x = $urandom_range(0, (1 << top) - 1);
        y = $urandom_range(0, (1 << top) - 1);
      end
      last_x     = x;
      last_y     = y;
      have_pixel = 1'b1;
      send_item(ACT_TURN_ON, LVL_W'($urandom), COORD_W'(x), COORD_W'(y));
    end else if (pick < 85) begin
      lvl = $urandom_range(lo, top);
      if (have_pixel && lvl <= top && $urandom_range(0, 1)) begin
        sh = top - lvl;
        x  = last_x >> sh;
        y  = last_y >> sh;
      end else begin
        x = $urandom_range(0, (1 << lvl) - 1);
        y = $urandom_range(0, (1 << lvl) - 1);
      end
      send_item(ACT_QUERY, LVL_W'(lvl), COORD_W'(x), COORD_W'(y));
    end else begin
      case ($urandom_range(0, 2))
        0:       act = ACT_TURN_ON;
        1:       act = ACT_QUERY;
        default: act = ACT_UNKNOWN;
      endcase
      send_item(act, LVL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  initial begin
    int mn, mx, clear_at;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ACT_TURN_ON;
    level_i     = '0;
    x_coord_i   = '0;
    y_coord_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MIN_LEVEL;
    cfg_data_i  = '0;
    tx_mode     = 0;
    rx_mode     = 1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    write_level_reg(REG_MIN_LEVEL, 4'd0);
    write_level_reg(REG_ACTIVE_MAX, 4'd8);
    send_item(ACT_QUERY, 4'd0, 8'd0, 8'd0);
    send_item(ACT_TURN_ON, 4'd0, 8'd255, 8'd255);
    send_item(ACT_TURN_ON, 4'd0, 8'd0, 8'd0);
    send_item(ACT_TURN_ON, 4'd0, 8'd0, 8'd0);       // double turn-on
    send_item(ACT_TURN_ON, 4'd15, 8'd1, 8'd0);
    send_item(ACT_QUERY, 4'd8, 8'd255, 8'd255);
    send_item(ACT_QUERY, 4'd0, 8'd0, 8'd0);
    send_item(ACT_QUERY, 4'd7, 8'd0, 8'd0);
    send_item(ACT_QUERY, 4'd15, 8'd0, 8'd0);        // level above range
    send_item(ACT_QUERY, 4'd1, 8'd2, 8'd0);         // coordinate off the level
    send_item(ACT_UNKNOWN, 4'd3, 8'd7, 8'd9);
    drain();

    tx_mode = 1;
    write_level_reg(REG_ACTIVE_MAX, 4'd1);
    send_item(ACT_QUERY, 4'd1, 8'd0, 8'd0);         // overfull cell
    send_item(ACT_TURN_ON, 4'd0, 8'd2, 8'd0);       // off the grid
    send_item(ACT_TURN_ON, 4'd0, 8'd0, 8'd0);
    send_item(ACT_TURN_ON, 4'd0, 8'd0, 8'd1);
    send_item(ACT_QUERY, 4'd0, 8'd0, 8'd0);
    drain();

    write_level_reg(REG_MIN_LEVEL, 4'd5);
    write_level_reg(REG_ACTIVE_MAX, 4'd2);
    send_item(ACT_TURN_ON, 4'd0, 8'd0, 8'd0);       // inverted levels
    send_item(ACT_QUERY, 4'd2, 8'd0, 8'd0);
    drain();

    write_level_reg(REG_MIN_LEVEL, 4'd15);
    write_level_reg(REG_ACTIVE_MAX, 4'd15);
    send_item(ACT_QUERY, 4'd8, 8'd0, 8'd0);
    send_item(ACT_QUERY, 4'd7, 8'd0, 8'd0);         // below min level
    send_item(ACT_TURN_ON, 4'd0, 8'd128, 8'd64);
    send_item(ACT_CLEAR, 4'd9, 8'd200, 8'd100);
    send_item(ACT_QUERY, 4'd8, 8'd128, 8'd64);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 10) begin
        mn = PHASE_MIN[p];
        mx = PHASE_TOP[p];
      end else begin
        mn = $urandom_range(0, 15);
        mx = $urandom_range(0, 15);
      end
      if ($urandom_range(0, 1)) begin
        write_level_reg(REG_MIN_LEVEL, LVL_W'(mn));
        write_level_reg(REG_ACTIVE_MAX, LVL_W'(mx));
      end else begin
        write_level_reg(REG_ACTIVE_MAX, LVL_W'(mx));
        write_level_reg(REG_MIN_LEVEL, LVL_W'(mn));
      end
      tx_mode  = p % 3;
      rx_mode  = (p / 3) % 3;
      clear_at = (p == 4 || p == 11) ? $urandom_range(10, 80) : -1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == clear_at) begin
          send_item(ACT_CLEAR, LVL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        end else begin
          send_random_item();
        end
        if (i % 30 == 29) begin
          tx_mode = $urandom_range(0, 2);
          rx_mode = $urandom_range(0, 2);
        end
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (book.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
